// ===== hw/rtl/s3lm_pkg.sv =====
// types, constants and the peak test shared by the local maximum finder
package s3lm_pkg;

  localparam int MAX_SIDE = 256;
  localparam int PIX_W    = 8;
  localparam int SIDE_W   = 9;
  localparam int COORD_W  = 8;
  localparam int CNT_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int TDATA_W  = ((PIX_W + 2 * COORD_W + 7) / 8) * 8;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last_row;
    logic             last_col;
    logic             bank;
  } pos_t;

  typedef struct packed {
    logic               kind;
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } result_t;

  // strict maximum over the existing 8-neighbours inside the window
  function automatic logic is_peak(input win_t w, input logic [2:0] row_ok,
                                   input logic [2:0] col_ok, input int ci, input int cj);
    logic ok;
    ok = row_ok[ci] && col_ok[cj];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == ci && j == cj) && i >= ci - 1 && i <= ci + 1 &&
            j >= cj - 1 && j <= cj + 1 && row_ok[i] && col_ok[j] &&
            w[i][j] >= w[ci][cj]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

// ===== hw/rtl/strict_3x3_local_max_finder_unit.sv =====
// Strict 3x3 local maximum finder: takes one 8-bit pixel per beat in raster
// order and reports each pixel strictly greater than all of its existing
// 8-neighbours, with its row and column, plus a frame-done beat after the last
// pixel. A pixel is reported when its last neighbour arrives, so reports are
// not always in raster order. The block accepts one pixel every clock cycle
// while the output keeps up; each taken pixel is held in the s1 register and its
// results are then loaded into the output queue. The only pixel that can make
// two result beats is the last of a frame. The line store takes one read of each
// bank and one write per pixel. A write to cfg_data sets the image side (0 acts
// as 1, values above 256 act as 256) and restarts the frame at row 0, column 0.
module strict_3x3_local_max_finder_unit
  import s3lm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SIDE_W-1:0]  cfg_data,    // image_side
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [PIX_W-1:0]   s_tdata,     // pixel_value
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,     // peak_value, peak_row, peak_col
  output logic               m_tuser,     // report_kind
  output logic               m_tlast      // run_last
);

  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic             s1_valid;
  pos_t             s1_pos;
  pos_t             in_pos;
  logic [PIX_W-1:0] s1_px;
  logic             accept;
  logic             s1_go;
  logic             s1_fire;
  logic [PIX_W-1:0] rd0;
  logic [PIX_W-1:0] rd1;
  logic [PIX_W-1:0] top_px;
  logic [PIX_W-1:0] mid_px;
  result_t [1:0]    res;
  logic [1:0]       num;
  logic [CNT_W-1:0] cfg_last_idx;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign s1_fire   = s1_valid && s1_go;
  assign s_tready  = !s1_valid || s1_go;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_last_idx = '0;
    end else if (32'(cfg_data) > MAX_SIDE) begin
      cfg_last_idx = CNT_W'(MAX_SIDE - 1);
    end else begin
      cfg_last_idx = CNT_W'(cfg_data - SIDE_W'(1));
    end
  end

  always_comb begin
    in_pos.row      = row_count;
    in_pos.col      = col_count;
    in_pos.last_row = row_count == last_idx;
    in_pos.last_col = col_count == last_idx;
    in_pos.bank     = row_count[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_idx  <= CNT_W'(MAX_SIDE - 1);
      row_count <= '0;
      col_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      last_idx  <= cfg_last_idx;
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (in_pos.last_col) begin
        col_count <= '0;
        row_count <= in_pos.last_row ? '0 : row_count + CNT_W'(1);
      end else begin
        col_count <= col_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos <= in_pos;
      s1_px  <= s_tdata;
    end
  end

  s3lm_line_buf u_line_buf (
    .clk     (clk),
    .en      (accept),
    .wr_bank (in_pos.bank),
    .addr    (col_count),
    .wdata   (s_tdata),
    .rd0     (rd0),
    .rd1     (rd1)
  );

  // current bank holds the row two above, the other bank the row just above
  assign top_px = s1_pos.bank ? rd1 : rd0;
  assign mid_px = s1_pos.bank ? rd0 : rd1;

  s3lm_window u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_fire),
    .top_px  (top_px),
    .mid_px  (mid_px),
    .new_px  (s1_px),
    .pos     (s1_pos),
    .res     (res),
    .num     (num)
  );

  s3lm_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_fire),
    .res      (res),
    .num      (num),
    .can_load (s1_go),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hw/rtl/s3lm_line_buf.sv =====
// two-bank line store, one read of each bank and one write per pixel
module s3lm_line_buf
  import s3lm_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic             wr_bank,
  input  logic [CNT_W-1:0] addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rd0,
  output logic [PIX_W-1:0] rd1
);

  logic [PIX_W-1:0] bank0 [MAX_SIDE];
  logic [PIX_W-1:0] bank1 [MAX_SIDE];

  always_ff @(posedge clk) begin
    if (en) begin
      rd0 <= bank0[addr];
      rd1 <= bank1[addr];
      if (wr_bank) begin
        bank1[addr] <= wdata;
      end else begin
        bank0[addr] <= wdata;
      end
    end
  end

endmodule

// ===== hw/rtl/s3lm_window.sv =====
// 3x3 window registers and the peak and frame-end decision
module s3lm_window
  import s3lm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [PIX_W-1:0]    top_px,
  input  logic [PIX_W-1:0]    mid_px,
  input  logic [PIX_W-1:0]    new_px,
  input  pos_t                pos,
  output result_t [1:0]       res,
  output logic [1:0]          num
);

  win_t window;
  win_t window_next;
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic p11, p12, p21, p22;
  logic found;
  logic is_end;
  logic [1:0] fi;
  logic [1:0] fj;
  logic [CNT_W-1:0] pk_row;
  logic [CNT_W-1:0] pk_col;
  result_t peak_res;
  result_t done_res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      window_next[i][0] = window[i][1];
      window_next[i][1] = window[i][2];
    end
    window_next[0][2] = top_px;
    window_next[1][2] = mid_px;
    window_next[2][2] = new_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (advance) begin
      window <= window_next;
    end
  end

  assign row_ok = {1'b1, pos.row != '0, pos.row > CNT_W'(1)};
  assign col_ok = {1'b1, pos.col != '0, pos.col > CNT_W'(1)};

  assign p11 = is_peak(window_next, row_ok, col_ok, 1, 1);
  assign p12 = pos.last_col && is_peak(window_next, row_ok, col_ok, 1, 2);
  assign p21 = pos.last_row && is_peak(window_next, row_ok, col_ok, 2, 1);
  assign p22 = pos.last_row && pos.last_col &&
               is_peak(window_next, row_ok, col_ok, 2, 2);

  assign found  = p11 || p12 || p21 || p22;
  assign is_end = pos.last_row && pos.last_col;

  always_comb begin
    fi = 2'd2;
    fj = 2'd2;
    if (p11) begin
      fi = 2'd1;
      fj = 2'd1;
    end else if (p12) begin
      fi = 2'd1;
      fj = 2'd2;
    end else if (p21) begin
      fi = 2'd2;
      fj = 2'd1;
    end
  end

  assign pk_row = (fi == 2'd1) ? pos.row - CNT_W'(1) : pos.row;
  assign pk_col = (fj == 2'd1) ? pos.col - CNT_W'(1) : pos.col;

  always_comb begin
    peak_res.kind  = KIND_PEAK;
    peak_res.value = window_next[fi][fj];
    peak_res.row   = COORD_W'(pk_row);
    peak_res.col   = COORD_W'(pk_col);
    peak_res.last  = !is_end;
    done_res       = '0;
    done_res.kind  = KIND_DONE;
    done_res.last  = 1'b1;
    res[0] = found ? peak_res : done_res;
    res[1] = done_res;
    num    = {1'b0, found} + {1'b0, is_end};
  end

endmodule

// ===== hw/rtl/s3lm_out_queue.sv =====
// two-entry result buffer driving the output stream
module s3lm_out_queue
  import s3lm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  result_t [1:0] res,
  input  logic [1:0]    num,
  output logic          can_load,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic          m_tlast,
  output logic          m_tuser,
  output logic [TDATA_W-1:0] m_tdata
);

  result_t q0;
  result_t q1;
  logic [1:0] count;
  logic take;

  assign m_tvalid = count != 2'd0;
  assign take     = m_tvalid && m_tready;
  assign can_load = (count == 2'd0) || (count == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= num;
    end else if (take) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0 <= res[0];
      q1 <= res[1];
    end else if (take) begin
      q0 <= q1;
    end
  end

  assign m_tlast = q0.last;
  assign m_tuser = q0.kind;
  assign m_tdata = TDATA_W'({q0.col, q0.row, q0.value});

endmodule
